// ===== rtl/cnsf_pkg.sv =====
// Shared types and constants of the cell node spring force block.
// Used by the sequencer, datapath and top level of the block; depends on nothing else.
package cnsf_pkg;

   localparam int TAG_W       = 8;
   localparam int GAIN_W      = 32;
   localparam int FORCE_W     = 48;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 96;

   // Operation codes carried in the request tuser.
   localparam logic [1:0] OP_TAG_WRITE  = 2'd0;
   localparam logic [1:0] OP_COMPUTE    = 2'd1;
   localparam logic [1:0] OP_FORCE_READ = 2'd2;

   // Result kinds carried in the response tuser.
   localparam logic KIND_DONE  = 1'b0;
   localparam logic KIND_FORCE = 1'b1;

   // Register indexes on the configuration port.
   localparam logic REG_CELL_COUNT = 1'b0;
   localparam logic REG_FORCE_GAIN = 1'b1;

   typedef struct packed {
      logic clear_begin;
      logic clear_step;
      logic tag_write;
      logic load_read;
      logic scan_init;
      logic tag_step;
      logic mask_load;
      logic cell_update;
      logic f_prod;
      logic f_sub;
      logic f_mul;
      logic f_acc;
      logic next_node;
      logic out_load;
      logic out_kind;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic tag_done;
      logic mask_empty;
      logic scan_last;
      logic item_in_range;
      logic out_free;
   } sts_type;

endpackage

// ===== rtl/cnsf_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
// Stand-alone; no package needed.
module cnsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cnsf_ctrl.sv =====
// Sequencer of the cell node spring force block: steps the datapath through
// clearing, tag writes, the node scan and force reads. Uses cnsf_pkg.
module cnsf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic [1:0]        req_op,
   output logic              req_tready,
   input  cnsf_pkg::sts_type sts,
   output cnsf_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_RCLR, ST_IDLE, ST_CCLR, ST_TAGS, ST_MASK, ST_CHK, ST_CRD, ST_CWR,
      ST_FRD, ST_FPROD, ST_FSUB, ST_FMUL, ST_FACC, ST_NEXT, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      read_ff, read_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      read_in  = read_ff;
      case (state_ff)
         ST_RCLR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_op)
                  cnsf_pkg::OP_TAG_WRITE: begin
                     cmd.tag_write = 1'b1;
                  end
                  cnsf_pkg::OP_COMPUTE: begin
                     cmd.clear_begin = 1'b1;
                     read_in         = 1'b0;
                     state_in        = ST_CCLR;
                  end
                  cnsf_pkg::OP_FORCE_READ: begin
                     cmd.load_read = 1'b1;
                     read_in       = 1'b1;
                     state_in      = sts.item_in_range ? ST_TAGS : ST_DONE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CCLR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               cmd.scan_init = 1'b1;
               state_in      = ST_TAGS;
            end
         end
         ST_TAGS: begin
            cmd.tag_step = 1'b1;
            if (sts.tag_done) begin
               state_in = ST_MASK;
            end
         end
         ST_MASK: begin
            cmd.mask_load = 1'b1;
            state_in      = ST_CHK;
         end
         ST_CHK: begin
            if (sts.mask_empty) begin
               state_in = read_ff ? ST_DONE : ST_NEXT;
            end else begin
               state_in = read_ff ? ST_FRD : ST_CRD;
            end
         end
         ST_CRD: begin
            state_in = ST_CWR;
         end
         ST_CWR: begin
            cmd.cell_update = 1'b1;
            state_in        = ST_CHK;
         end
         ST_FRD: begin
            state_in = ST_FPROD;
         end
         ST_FPROD: begin
            cmd.f_prod = 1'b1;
            state_in   = ST_FSUB;
         end
         ST_FSUB: begin
            cmd.f_sub = 1'b1;
            state_in  = ST_FMUL;
         end
         ST_FMUL: begin
            cmd.f_mul = 1'b1;
            state_in  = ST_FACC;
         end
         ST_FACC: begin
            cmd.f_acc = 1'b1;
            state_in  = ST_CHK;
         end
         ST_NEXT: begin
            cmd.next_node = 1'b1;
            state_in      = sts.scan_last ? ST_DONE : ST_TAGS;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = read_ff ? cnsf_pkg::KIND_FORCE : cnsf_pkg::KIND_DONE;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RCLR;
         read_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         read_ff  <= read_in;
      end
   end

`ifndef SYNTHESIS
   a_out_free : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free) else $error("result loaded over a pending one");
   a_cell_sel : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CRD || state_ff == ST_FRD) |-> !sts.mask_empty)
      else $error("cell access with no member cell left");
   a_cell_wr_mode : assert property (@(posedge clock) disable iff (reset)
      cmd.cell_update |-> !read_ff) else $error("cell sums written during a read");
   a_clear_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !req_tready) else $error("item taken during a clear");
`endif

endmodule

// ===== rtl/cnsf_dp.sv =====
// Datapath of the cell node spring force block: tag store, per-cell sum store,
// node scan registers, force arithmetic and the result register. Uses cnsf_pkg.
module cnsf_dp #(
   parameter int VOXELS_X  = 64,
   parameter int VOXELS_Y  = 64,
   parameter int MAX_CELLS = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cnsf_pkg::cmd_type                cmd,
   output cnsf_pkg::sts_type                sts,
   input  logic [5:0]                       voxel_x,
   input  logic [5:0]                       voxel_y,
   input  logic [cnsf_pkg::TAG_W-1:0]       cell_tag,
   input  logic [6:0]                       node_x,
   input  logic [6:0]                       node_y,
   input  logic [7:0]                       cell_count,
   input  logic [cnsf_pkg::GAIN_W-1:0]      force_gain,
   input  logic                             rsp_tready,
   output logic                             rsp_tvalid,
   output logic                             rsp_kind,
   output logic [cnsf_pkg::FORCE_W-1:0]     rsp_force_x,
   output logic [cnsf_pkg::FORCE_W-1:0]     rsp_force_y
);

   localparam int VT      = VOXELS_X * VOXELS_Y;
   localparam int TAG_AW  = $clog2(VT);
   localparam int CELL_AW = MAX_CELLS > 1 ? $clog2(MAX_CELLS) : 1;
   localparam int XW      = $clog2(VOXELS_X);
   localparam int YW      = $clog2(VOXELS_Y);
   localparam int CW      = XW > YW ? XW : YW;
   localparam int CNT_W   = $clog2((VOXELS_X - 1) * (VOXELS_Y - 1) + 1);
   localparam int SUM_W   = CNT_W + CW;
   localparam int CELL_DW = CNT_W + 2 * SUM_W;
   localparam int DX_W    = SUM_W + 1;
   localparam int PROD_W  = cnsf_pkg::GAIN_W + 1 + DX_W;
   localparam int ACC_W0  = PROD_W + 2;
   localparam int ACC_W   = ACC_W0 > 49 ? ACC_W0 : 49;
   localparam int CLR_N   = VT > MAX_CELLS ? VT : MAX_CELLS;
   localparam int CLR_W   = $clog2(CLR_N);
   localparam int FW      = cnsf_pkg::FORCE_W;

   localparam logic [TAG_AW-1:0] VX_A = TAG_AW'(VOXELS_X);
   localparam logic signed [ACC_W-1:0] F_MAX = {{(ACC_W - FW + 1){1'b0}}, {(FW - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] F_MIN = {{(ACC_W - FW + 1){1'b1}}, {(FW - 1){1'b0}}};

   logic [CLR_W-1:0]             clr_ff;
   logic                         clr_all_ff;
   logic [CW-1:0]                nx_ff, ny_ff;
   logic [2:0]                   k_ff;
   logic [cnsf_pkg::TAG_W-1:0]   tag_ff [4];
   logic [3:0]                   mask_ff, mask_in;
   logic [SUM_W-1:0]             cnx_ff, cny_ff, sumx_ff, sumy_ff;
   logic signed [DX_W-1:0]       dx_ff, dy_ff;
   logic signed [PROD_W-1:0]     px_ff, py_ff;
   logic signed [ACC_W-1:0]      accx_ff, accy_ff;
   logic                         rsp_valid_ff, rsp_kind_ff;
   logic [FW-1:0]                fx_ff, fy_ff, fx_sat, fy_sat;

   logic [1:0]                   sel;
   logic [31:0]                  cell_idx;
   logic [CELL_AW-1:0]           cell_addr;
   logic [TAG_AW-1:0]            vx_a, vy_a, tag_rd_addr, tag_wr_addr;
   logic [31:0]                  ivx, ivy, inx, iny;
   logic                         in_grid;
   logic                         tag_wr_en, cell_wr_en;
   logic [cnsf_pkg::TAG_W-1:0]   tag_wr_data, tag_rd_data;
   logic [CELL_AW-1:0]           cell_wr_addr;
   logic [CELL_DW-1:0]           cell_wr_data, cell_rd_data;
   logic [CNT_W-1:0]             rd_cnt;
   logic [SUM_W-1:0]             rd_sx, rd_sy;
   logic                         clr_tag_ok, clr_cell_ok;

   // Item decoding.
   assign ivx         = 32'(voxel_x);
   assign ivy         = 32'(voxel_y);
   assign inx         = 32'(node_x);
   assign iny         = 32'(node_y);
   assign in_grid     = (ivx < VOXELS_X) && (ivy < VOXELS_Y);
   assign tag_wr_addr = TAG_AW'(ivx + ivy * VOXELS_X);

   // Voxel k of the current node: bit 0 of k steps in x, bit 1 in y.
   assign vx_a        = TAG_AW'(nx_ff) - TAG_AW'(1) + TAG_AW'(k_ff[0]);
   assign vy_a        = TAG_AW'(ny_ff) - TAG_AW'(1) + TAG_AW'(k_ff[1]);
   assign tag_rd_addr = vx_a + vy_a * VX_A;

   assign clr_tag_ok  = clr_all_ff && (32'(clr_ff) < VT);
   assign clr_cell_ok = 32'(clr_ff) < MAX_CELLS;

   assign tag_wr_en   = (cmd.clear_step && clr_tag_ok) || (cmd.tag_write && in_grid);
   assign tag_wr_data = cmd.clear_step ? '0 : cell_tag;

   cnsf_ram #(.WIDTH(cnsf_pkg::TAG_W), .DEPTH(VT)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (cmd.clear_step ? TAG_AW'(clr_ff) : tag_wr_addr),
      .wr_data (tag_wr_data),
      .rd_addr (tag_rd_addr),
      .rd_data (tag_rd_data)
   );

   // Lowest member cell still pending.
   always_comb begin
      if (mask_ff[0]) begin
         sel = 2'd0;
      end else if (mask_ff[1]) begin
         sel = 2'd1;
      end else if (mask_ff[2]) begin
         sel = 2'd2;
      end else begin
         sel = 2'd3;
      end
   end

   assign cell_idx  = 32'(tag_ff[sel]) - 32'd1;
   assign cell_addr = cell_idx[CELL_AW-1:0];

   assign rd_cnt = cell_rd_data[CNT_W-1:0];
   assign rd_sx  = cell_rd_data[CNT_W +: SUM_W];
   assign rd_sy  = cell_rd_data[CNT_W + SUM_W +: SUM_W];

   assign cell_wr_en   = (cmd.clear_step && clr_cell_ok) || cmd.cell_update;
   assign cell_wr_addr = cmd.clear_step ? CELL_AW'(clr_ff) : cell_addr;
   assign cell_wr_data = cmd.clear_step ? '0 :
                         {rd_sy + SUM_W'(ny_ff), rd_sx + SUM_W'(nx_ff), rd_cnt + CNT_W'(1)};

   cnsf_ram #(.WIDTH(CELL_DW), .DEPTH(MAX_CELLS)) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_wr_en),
      .wr_addr (cell_wr_addr),
      .wr_data (cell_wr_data),
      .rd_addr (cell_addr),
      .rd_data (cell_rd_data)
   );

   // A tag names a member cell when it is non-zero, within the cell count and
   // the store, and not already seen at a lower voxel of the same node.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         mask_in[k] = (tag_ff[k] != '0) && (32'(tag_ff[k]) <= 32'(cell_count)) &&
                      (32'(tag_ff[k]) <= MAX_CELLS);
         for (int j = 0; j < 4; j++) begin
            if (j < k && tag_ff[j] == tag_ff[k]) begin
               mask_in[k] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      if (accx_ff > F_MAX) begin
         fx_sat = F_MAX[FW-1:0];
      end else if (accx_ff < F_MIN) begin
         fx_sat = F_MIN[FW-1:0];
      end else begin
         fx_sat = accx_ff[FW-1:0];
      end
      if (accy_ff > F_MAX) begin
         fy_sat = F_MAX[FW-1:0];
      end else if (accy_ff < F_MIN) begin
         fy_sat = F_MIN[FW-1:0];
      end else begin
         fy_sat = accy_ff[FW-1:0];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         clr_all_ff   <= 1'b1;
         k_ff         <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_begin) begin
            clr_ff     <= '0;
            clr_all_ff <= 1'b0;
         end else if (cmd.clear_step) begin
            clr_ff <= clr_ff + CLR_W'(1);
         end
         if (cmd.load_read || cmd.scan_init || cmd.next_node) begin
            k_ff <= '0;
         end else if (cmd.tag_step) begin
            k_ff <= k_ff + 3'd1;
         end
         if (cmd.mask_load) begin
            mask_ff <= mask_in;
         end else if (cmd.cell_update || cmd.f_acc) begin
            mask_ff[sel] <= 1'b0;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_read) begin
         nx_ff <= CW'(inx);
         ny_ff <= CW'(iny);
      end else if (cmd.scan_init) begin
         nx_ff <= CW'(1);
         ny_ff <= CW'(1);
      end else if (cmd.next_node) begin
         if (nx_ff == CW'(VOXELS_X - 1)) begin
            nx_ff <= CW'(1);
            ny_ff <= ny_ff + CW'(1);
         end else begin
            nx_ff <= nx_ff + CW'(1);
         end
      end
      if (cmd.tag_step && k_ff != 3'd0) begin
         tag_ff[k_ff[1:0] - 2'd1] <= tag_rd_data;
      end
      if (cmd.f_prod) begin
         cnx_ff  <= SUM_W'(rd_cnt) * SUM_W'(nx_ff);
         cny_ff  <= SUM_W'(rd_cnt) * SUM_W'(ny_ff);
         sumx_ff <= rd_sx;
         sumy_ff <= rd_sy;
      end
      if (cmd.f_sub) begin
         dx_ff <= $signed({1'b0, sumx_ff}) - $signed({1'b0, cnx_ff});
         dy_ff <= $signed({1'b0, sumy_ff}) - $signed({1'b0, cny_ff});
      end
      if (cmd.f_mul) begin
         px_ff <= $signed({1'b0, force_gain}) * dx_ff;
         py_ff <= $signed({1'b0, force_gain}) * dy_ff;
      end
      if (cmd.load_read) begin
         accx_ff <= '0;
         accy_ff <= '0;
      end else if (cmd.f_acc) begin
         accx_ff <= accx_ff + ACC_W'(px_ff);
         accy_ff <= accy_ff + ACC_W'(py_ff);
      end
      if (cmd.out_load) begin
         rsp_kind_ff <= cmd.out_kind;
         fx_ff       <= (cmd.out_kind == cnsf_pkg::KIND_FORCE) ? fx_sat : '0;
         fy_ff       <= (cmd.out_kind == cnsf_pkg::KIND_FORCE) ? fy_sat : '0;
      end
   end

   assign sts.clear_last    = clr_all_ff ? (clr_ff == CLR_W'(CLR_N - 1))
                                         : (clr_ff == CLR_W'(MAX_CELLS - 1));
   assign sts.tag_done      = (k_ff == 3'd4);
   assign sts.mask_empty    = (mask_ff == '0);
   assign sts.scan_last     = (nx_ff == CW'(VOXELS_X - 1)) && (ny_ff == CW'(VOXELS_Y - 1));
   assign sts.item_in_range = (inx >= 32'd1) && (inx < VOXELS_X) &&
                              (iny >= 32'd1) && (iny < VOXELS_Y);
   assign sts.out_free      = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_force_x = fx_ff;
   assign rsp_force_y = fy_ff;

endmodule

// ===== rtl/cell_node_spring_forces.sv =====
// A tag write is taken while idle; a force read of an in-range node gathers its tags,
// then runs each member cell through the force steps to its result; a compute clears
// the cell sums, then scans every interior node and adds it to its member cells.
// One item is in work at a time; the tag store read port sets the node pace.
// Reset: synchronous, active high; afterwards a clearing pass over both stores
// zeroes them before items are taken.
module cell_node_spring_forces #(
   parameter int VOXELS_X  = 64,
   parameter int VOXELS_Y  = 64,
   parameter int MAX_CELLS = 256
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // voxel_x[5:0], voxel_y[11:6], cell_tag[19:12], node_x[26:20], node_y[33:27], zero fill
   input  logic [cnsf_pkg::REQ_TDATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]  req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // force_x[47:0], force_y[95:48]
   output logic [cnsf_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // result_kind[0]
   output logic        rsp_tuser,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Registers live here; the sequencer and datapath see only their values.
   logic [7:0]                      cell_count_ff;
   logic [cnsf_pkg::GAIN_W-1:0]     force_gain_ff;
   logic                            csr_wr;
   logic                            reg_idx;

   cnsf_pkg::cmd_type               cmd;
   cnsf_pkg::sts_type               sts;
   logic [cnsf_pkg::FORCE_W-1:0]    force_x, force_y;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_count_ff <= 8'd0;
         force_gain_ff <= 32'd65536;
      end else if (csr_wr) begin
         case (reg_idx)
            cnsf_pkg::REG_CELL_COUNT: cell_count_ff <= csr_pwdata[7:0];
            cnsf_pkg::REG_FORCE_GAIN: force_gain_ff <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         cnsf_pkg::REG_CELL_COUNT: csr_prdata = {24'd0, cell_count_ff};
         cnsf_pkg::REG_FORCE_GAIN: csr_prdata = force_gain_ff;
         default:                  csr_prdata = '0;
      endcase
   end

   // The sequencer takes a transfer only when idle; the result register in the
   // datapath lets a new transfer in while the last result still waits.
   cnsf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cnsf_dp #(
      .VOXELS_X  (VOXELS_X),
      .VOXELS_Y  (VOXELS_Y),
      .MAX_CELLS (MAX_CELLS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .voxel_x     (req_tdata[5:0]),
      .voxel_y     (req_tdata[11:6]),
      .cell_tag    (req_tdata[19:12]),
      .node_x      (req_tdata[26:20]),
      .node_y      (req_tdata[33:27]),
      .cell_count  (cell_count_ff),
      .force_gain  (force_gain_ff),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_kind    (rsp_tuser),
      .rsp_force_x (force_x),
      .rsp_force_y (force_y)
   );

   assign rsp_tdata = {force_y, force_x};

endmodule

// ===== test/cell_node_spring_forces_tb.sv =====
// Self-checking testbench for cell_node_spring_forces: drives tag writes, cell sum
// computes and node force reads, predicts every result and checks it. Depends on
// cnsf_pkg and the cell_node_spring_forces top level only.
`timescale 1ns / 1ps

module cell_node_spring_forces_tb;

   // Operation code 3 is not used by the block; it must be swallowed silently.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int GRID = 64;
   localparam int CELLS = 256;
   localparam longint FORCE_MAX = 64'sh7FFF_FFFF_FFFF;
   localparam longint FORCE_MIN = -FORCE_MAX - 1;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int HOLD_CYCLES = 3000;

   typedef struct {
      logic [1:0] op;
      logic [5:0] vx;
      logic [5:0] vy;
      logic [7:0] tag;
      logic [6:0] nx;
      logic [6:0] ny;
   } grid_req_type;

   typedef struct {
      logic        kind;
      logic [47:0] fx;
      logic [47:0] fy;
   } force_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [cnsf_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [cnsf_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // Shadow of the block's state, kept in step with accepted transfers.
   logic [7:0] tag_shadow [GRID*GRID];
   int unsigned member_count [CELLS];
   longint sum_x [CELLS];
   longint sum_y [CELLS];
   int unsigned cell_limit = 0;
   longint unsigned gain = 65536;

   grid_req_type pend_q[$];
   force_rsp_type expected_q[$];
   int errors = 0;
   int rsp_seen = 0;
   bit quiet = 1'b0;
   int cycles = 0;

   always #5 clock = ~clock;

   cell_node_spring_forces u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   // Distinct valid cells around an interior node, taken from the current tags and
   // the current cell count. A tag shared by several voxels is listed once.
   function automatic int node_members(int nx, int ny, output int cl[4]);
      int n;
      int t;
      bit seen;
      n = 0;
      for (int dy = 0; dy < 2; dy++) begin
         for (int dx = 0; dx < 2; dx++) begin
            t = int'(tag_shadow[(nx - 1 + dx) + (ny - 1 + dy) * GRID]);
            if (t != 0 && t <= int'(cell_limit)) begin
               seen = 1'b0;
               for (int k = 0; k < n; k++)
                  if (cl[k] == t - 1) seen = 1'b1;
               if (!seen) begin
                  cl[n] = t - 1;
                  n++;
               end
            end
         end
      end
      return n;
   endfunction

   function automatic logic [47:0] clip48(longint v);
      if (v > FORCE_MAX) return FORCE_MAX[47:0];
      if (v < FORCE_MIN) return FORCE_MIN[47:0];
      return v[47:0];
   endfunction

   // Applies one accepted request to the shadow state and queues its result, if any.
   function automatic void predict_cell_forces(grid_req_type r);
      force_rsp_type e;
      int cl[4];
      int n;
      longint fx;
      longint fy;
      case (r.op)
         cnsf_pkg::OP_TAG_WRITE: begin
            tag_shadow[int'(r.vx) + int'(r.vy) * GRID] = r.tag;
         end
         cnsf_pkg::OP_COMPUTE: begin
            for (int c = 0; c < CELLS; c++) begin
               member_count[c] = 0;
               sum_x[c] = 0;
               sum_y[c] = 0;
            end
            for (int y = 1; y < GRID; y++)
               for (int x = 1; x < GRID; x++) begin
                  n = node_members(x, y, cl);
                  for (int k = 0; k < n; k++) begin
                     member_count[cl[k]]++;
                     sum_x[cl[k]] += x;
                     sum_y[cl[k]] += y;
                  end
               end
            e.kind = cnsf_pkg::KIND_DONE;
            e.fx = '0;
            e.fy = '0;
            expected_q.push_back(e);
         end
         cnsf_pkg::OP_FORCE_READ: begin
            fx = 0;
            fy = 0;
            if (r.nx >= 1 && r.nx < GRID && r.ny >= 1 && r.ny < GRID) begin
               n = node_members(int'(r.nx), int'(r.ny), cl);
               for (int k = 0; k < n; k++) begin
                  fx += longint'(gain) * (sum_x[cl[k]] -
                        longint'(member_count[cl[k]]) * longint'(r.nx));
                  fy += longint'(gain) * (sum_y[cl[k]] -
                        longint'(member_count[cl[k]]) * longint'(r.ny));
               end
            end
            e.kind = cnsf_pkg::KIND_FORCE;
            e.fx = clip48(fx);
            e.fy = clip48(fy);
            expected_q.push_back(e);
         end
         default: ;
      endcase
   endfunction

   // Request driver. The item at the head of the queue is the one on the bus; it
   // leaves the queue on the transfer, which is also when it is predicted.
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_cell_forces(pend_q[0]);
            void'(pend_q.pop_front());
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
               req_gap = int'($urandom_range(0, 13));
               req_tvalid <= 1'b0;
            end else if (pend_q.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tuser <= pend_q[0].op;
               req_tdata <= {6'b0, pend_q[0].ny, pend_q[0].nx, pend_q[0].tag,
                             pend_q[0].vy, pend_q[0].vx};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response acceptance. Once, early in the run, the receiver holds off for a long
   // stretch so that the block fills and has to stall its request side.
   int rsp_stall = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && rsp_seen >= 200) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_stall = int'($urandom_range(0, 13));
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checker: every transfer is compared with the oldest expectation.
   always @(posedge clock) begin
      force_rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result kind %0b x %h y %h", $time, rsp_tuser,
                     rsp_tdata[47:0], rsp_tdata[95:48]);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_tuser !== e.kind) begin
               $display("%0t: result_kind expected %0b actual %0b", $time, e.kind, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[47:0] !== e.fx) begin
               $display("%0t: force_x expected %h actual %h", $time, e.fx, rsp_tdata[47:0]);
               errors++;
            end
            if (rsp_tdata[95:48] !== e.fy) begin
               $display("%0t: force_y expected %h actual %h", $time, e.fy, rsp_tdata[95:48]);
               errors++;
            end
         end
      end
   end

   // Watchdog: the slowest correct run is far below this limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("cell_node_spring_forces: mismatch");
         $finish;
      end
   end

   // Every field is randomised so that unused fields also toggle; the caller then
   // sets the fields the operation actually uses.
   function automatic grid_req_type rand_req(logic [1:0] op);
      grid_req_type r;
      r.op = op;
      r.vx = 6'($urandom);
      r.vy = 6'($urandom);
      r.tag = 8'($urandom);
      r.nx = 7'($urandom);
      r.ny = 7'($urandom);
      return r;
   endfunction

   task automatic push_tag(int x, int y, int t);
      grid_req_type r;
      r = rand_req(cnsf_pkg::OP_TAG_WRITE);
      r.vx = 6'(x);
      r.vy = 6'(y);
      r.tag = 8'(t);
      pend_q.push_back(r);
   endtask

   task automatic push_read(int x, int y);
      grid_req_type r;
      r = rand_req(cnsf_pkg::OP_FORCE_READ);
      r.nx = 7'(x);
      r.ny = 7'(y);
      pend_q.push_back(r);
   endtask

   // Waits for the block to drain; a trailing tag write gives no result, so the task
   // waits on further before the registers are touched.
   task automatic drain();
      while (pend_q.size() > 0 || expected_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == cnsf_pkg::REG_CELL_COUNT) cell_limit = 32'(value[7:0]);
      else gain = 64'(value);
   endtask

   task automatic configure(int cc, logic [31:0] g);
      drain();
      csr_write(cnsf_pkg::REG_CELL_COUNT, cc);
      csr_write(cnsf_pkg::REG_FORCE_GAIN, g);
   endtask

   // A mixed phase: tag writes in a corner region of the given size, one compute
   // in the middle, then mostly force reads; a little unused-operation noise.
   task automatic run_mix(int n, int region, int max_tag);
      int r;
      for (int i = 0; i < n; i++) begin
         r = int'($urandom_range(0, 99));
         if (i == n / 2) pend_q.push_back(rand_req(cnsf_pkg::OP_COMPUTE));
         else if (r < 3) pend_q.push_back(rand_req(OP_UNUSED));
         else if (r < ((i < n / 2) ? 75 : 25))
            push_tag(int'($urandom_range(0, region - 1)), int'($urandom_range(0, region - 1)),
                     ($urandom_range(0, 19) == 0) ? 255 : int'($urandom_range(0, max_tag)));
         else if ($urandom_range(0, 9) == 0)
            push_read(int'($urandom_range(0, 127)), int'($urandom_range(0, 127)));
         else
            push_read(int'($urandom_range(0, 64)), int'($urandom_range(0, 64)));
      end
   endtask

   initial begin
      for (int i = 0; i < GRID * GRID; i++) tag_shadow[i] = '0;
      for (int c = 0; c < CELLS; c++) begin
         member_count[c] = 0;
         sum_x[c] = 0;
         sum_y[c] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: grid corners, an out-of-range tag, a node whose voxels repeat a
      // tag, boundary and out-of-grid reads, stale sums after a late write.
      configure(3, 32'd65536);
      push_tag(0, 0, 255);
      push_tag(63, 63, 1);
      push_tag(63, 0, 2);
      push_tag(0, 63, 3);
      push_tag(10, 10, 1);
      push_tag(11, 10, 1);
      push_tag(10, 11, 2);
      push_tag(11, 11, 3);
      pend_q.push_back(rand_req(OP_UNUSED));
      push_read(11, 11);
      pend_q.push_back(rand_req(cnsf_pkg::OP_COMPUTE));
      push_read(11, 11);
      push_read(0, 5);
      push_read(64, 5);
      push_read(5, 0);
      push_read(5, 64);
      push_read(127, 127);
      push_read(1, 1);
      push_read(63, 63);
      push_tag(20, 20, 1);
      push_read(21, 21);
      push_read(20, 20);

      // Saturation: three wide cells on the right edge pull node (1,1), which is a
      // member of all three, beyond the 48-bit range at the largest gain.
      configure(255, 32'hFFFF_FFFF);
      for (int y = 0; y < GRID; y++)
         for (int x = 55; x < GRID; x++)
            push_tag(x, y, (x >= 61) ? 1 : (x >= 58) ? 2 : 3);
      push_tag(0, 0, 1);
      push_tag(1, 0, 2);
      push_tag(0, 1, 3);
      pend_q.push_back(rand_req(cnsf_pkg::OP_COMPUTE));
      push_read(1, 1);
      for (int i = 0; i < 20; i++)
         push_read(int'($urandom_range(0, 64)), int'($urandom_range(0, 64)));

      configure(0, 32'd0);
      run_mix(150, 64, 255);
      configure(10, $urandom);
      run_mix(350, 16, 12);
      configure(4, 32'd1);
      run_mix(350, 8, 6);
      configure(200, $urandom);
      quiet = 1'b1;
      run_mix(350, 64, 255);

      while (pend_q.size() > 0 || expected_q.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("cell_node_spring_forces: match");
      end else begin
         $display("cell_node_spring_forces: mismatch");
      end
      $finish;
   end

endmodule
